// ----- sv/sst_pkg.sv -----
package sst_pkg;

  // Fixed field widths of the command and response channels.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_MEMBER  = 3'd2,
    CMD_GREATER = 3'd3,
    CMD_LESS    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_ISSUE,
    S_SRCH_CMP,
    S_PROBE,
    S_PROBE_CMP,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE_NEW,
    S_FINISH
  } state_t;

endpackage

// ----- sv/sst_store.sv -----
module sst_store import sst_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [VAL_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data
);

  // Single write port, single registered read port.
  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/sorted_set_table.sv -----
// sorted_set_table keeps a set of distinct signed 32-bit values in ascending order in a
// single-port-read, single-port-write memory of DEPTH entries, and answers one command
// per transfer on the cmd channel with one response transfer on the rsp channel. The
// commands are insert, delete, member test, count of elements greater than the value and
// count of elements less than the value; every response carries the set size after the
// command. Each command is served by signed comparisons on the memory's single read port
// under a small sequencer, so the block takes one command at a time: cmd_ready is high
// only while the sequencer is idle. A command first runs a binary search for the rank of
// its value, an issue state and a compare state per halving step and at most
// ceil(log2(N+1)) steps for N stored elements, plus a last issue state in which the
// search bounds are seen to meet. The entry at that rank is then probed (no read when
// the rank equals N) and an execute state decides. Inserts move every entry from the
// rank up by one place and deletes every entry above it, each move a memory read
// followed by a write, and an insert then writes the new value. A response passes
// through a finish state into the output register. The sequencer is idle again in the
// same cycle as the response becomes valid. The output register holds a finished response
// until it is taken, and the next command can be accepted while it waits. The count and
// set_size fields are seven bits wide; with DEPTH above 127 they carry the low seven bits
// of the true figures.
module sorted_set_table import sst_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [VAL_W-1:0]  value,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [STAT_W-1:0] status,
  output logic              found,
  output logic [CNT_W-1:0]  count,
  output logic [CNT_W-1:0]  set_size
);

  // AW indexes the memory; CW holds a count from 0 to DEPTH inclusive.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  state_t state, state_next;

  // Command being served.
  cmd_t               cmd_q;
  logic signed [31:0] value_q;

  // Binary search bounds and the probe address; lo ends as the rank of value_q.
  logic [CW-1:0] lo, hi, mid;
  logic [CW:0]   mid_sum;

  // Entry pointer and direction for the shift that opens or closes a gap.
  logic [CW-1:0] ptr;
  logic          shift_up;

  logic [CW-1:0] elem_count;
  logic          present;
  status_t       status_q;
  logic [CW-1:0] cnt_q;

  // Memory port.
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic signed [31:0] mem_rd_data;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [VAL_W-1:0]   mem_wr_data;

  logic cmd_xfer;
  logic rsp_free;
  logic shift_last;

  sst_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  assign cmd_ready = (state == S_IDLE);
  assign cmd_xfer  = cmd_valid && cmd_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};

  // The last move of a shift: going up it fills the slot just above the rank, going
  // down it fills the slot just below the old top entry.
  assign shift_last = shift_up ? ((ptr - ONE_C) == lo) : ((ptr + TWO_C) == elem_count);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_xfer) begin
          state_next = S_SRCH_ISSUE;
        end
      end
      S_SRCH_ISSUE: begin
        state_next = (lo < hi) ? S_SRCH_CMP : S_PROBE;
      end
      S_SRCH_CMP: begin
        state_next = S_SRCH_ISSUE;
      end
      S_PROBE: begin
        state_next = (lo < elem_count) ? S_PROBE_CMP : S_EXEC;
      end
      S_PROBE_CMP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_FINISH;
        if (cmd_q == CMD_INSERT && !present && elem_count != DEPTH_C) begin
          state_next = (lo == elem_count) ? S_WRITE_NEW : S_SHIFT_RD;
        end else if (cmd_q == CMD_DELETE && present && (lo + ONE_C) != elem_count) begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        if (shift_last) begin
          state_next = shift_up ? S_WRITE_NEW : S_FINISH;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_WRITE_NEW: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory control.
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = mem_rd_data;
    unique case (state)
      S_SRCH_ISSUE: begin
        mem_rd_en   = (lo < hi);
        mem_rd_addr = mid_sum[AW:1];
      end
      S_PROBE: begin
        mem_rd_en   = (lo < elem_count);
        mem_rd_addr = lo[AW-1:0];
      end
      S_SHIFT_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = shift_up ? AW'(ptr - ONE_C) : AW'(ptr + ONE_C);
      end
      S_SHIFT_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr[AW-1:0];
      end
      S_WRITE_NEW: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = lo[AW-1:0];
        mem_wr_data = value_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // A finished response is loaded only when the output register is free, so a
      // transfer and a new load can fall on the same edge.
      if (state == S_FINISH && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            cmd_q    <= cmd_t'(command);
            value_q  <= value;
            lo       <= '0;
            hi       <= elem_count;
            present  <= 1'b0;
            status_q <= ST_OK;
            cnt_q    <= '0;
          end
        end
        S_SRCH_ISSUE: begin
          mid <= mid_sum[CW:1];
        end
        S_SRCH_CMP: begin
          if (mem_rd_data < value_q) begin
            lo <= mid + ONE_C;
          end else begin
            hi <= mid;
          end
        end
        S_PROBE_CMP: begin
          present <= (mem_rd_data == value_q);
        end
        S_EXEC: begin
          unique case (cmd_q)
            CMD_INSERT: begin
              shift_up <= 1'b1;
              ptr      <= elem_count;
              if (present) begin
                status_q <= ST_PRESENT;
              end else if (elem_count == DEPTH_C) begin
                status_q <= ST_FULL;
              end
            end
            CMD_DELETE: begin
              shift_up <= 1'b0;
              ptr      <= lo;
              if (!present) begin
                status_q <= ST_ABSENT;
              end else if ((lo + ONE_C) == elem_count) begin
                elem_count <= elem_count - ONE_C;
              end
            end
            CMD_GREATER: begin
              cnt_q <= elem_count - lo - CW'(present);
            end
            CMD_LESS: begin
              cnt_q <= lo;
            end
            default: begin
            end
          endcase
        end
        S_SHIFT_WR: begin
          ptr <= shift_up ? (ptr - ONE_C) : (ptr + ONE_C);
          if (shift_last && !shift_up) begin
            elem_count <= elem_count - ONE_C;
          end
        end
        S_WRITE_NEW: begin
          elem_count <= elem_count + ONE_C;
        end
        S_FINISH: begin
          if (rsp_free) begin
            status    <= status_q;
            found     <= present;
            count     <= CNT_W'(cnt_q);
            set_size  <= CNT_W'(elem_count);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The stored size never exceeds the memory depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= DEPTH_C)
    else $error("element count exceeds depth");

  // Search bounds stay ordered and inside the stored range.
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH_ISSUE) |-> (lo <= hi && hi <= elem_count))
    else $error("binary search bounds out of order");

  // A new value is only written when there is room for it.
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE_NEW) |-> (elem_count < DEPTH_C && !present))
    else $error("insert write with full store or duplicate");

  // A full-store response reports a full set.
  a_full_size: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (set_size == CNT_W'(DEPTH)))
    else $error("full status with set size below depth");

  // One command at a time: after a command transfer the sequencer is busy.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer |=> !cmd_ready)
    else $error("command accepted while busy");

endmodule

// ----- tb/sv/tb_sorted_set_table.sv -----
`timescale 1ns / 1ps

module tb_sorted_set_table;
  import sst_pkg::*;

  // The store size used for this run. The predictor gets the same figure, so
  // full-store rejects are predicted at exactly the point where the block
  // runs out of room.
  localparam int unsigned TABLE_DEPTH = 64;

  // Command codes above the last defined command. The block must leave the set
  // alone for these and still report membership of the value.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam int VAL_MIN = 32'sh8000_0000;
  localparam int VAL_MAX = 32'sh7fff_ffff;

  // Length of the random part, and how long the bench keeps watching after the
  // last response for a response that the block should not produce.
  localparam int RANDOM_COMMANDS = 700;
  localparam int SETTLE_CYCLES   = 4 * TABLE_DEPTH + 64;

  // Predicts every response from the commands that the block accepts and holds
  // the predictions in order until the matching response transfer arrives.
  class set_scoreboard;
    typedef struct {
      status_t          st;
      logic             found;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] set_size;
    } response_t;

    int          capacity;
    int          members[$];     // the set, kept in ascending order
    response_t   awaited[$];     // predicted responses, oldest first
    int          errors;
    int          checked;
    int          cmd_seen[8];
    int          full_rejects;
    int          dup_rejects;
    int          absent_deletes;
    int          times_filled;

    function new(int depth);
      capacity = depth;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int size();
      return members.size();
    endfunction

    // Applies one accepted command to the local copy of the set and queues the
    // response that it must produce.
    function void note_command(logic [CMD_W-1:0] cmd, int val);
      int        below;
      int        above;
      bit        present;
      response_t r;
      below = 0;
      foreach (members[i])
        if (members[i] < val) below++;
      present = 1'b0;
      if (below < members.size())
        present = (members[below] == val);
      above = members.size() - below - (present ? 1 : 0);

      r.st    = ST_OK;
      r.found = present;
      r.count = '0;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_INSERT: begin
          if (present) begin
            // A duplicate is reported even when the store is also full.
            r.st = ST_PRESENT;
            dup_rejects++;
          end else if (members.size() >= capacity) begin
            r.st = ST_FULL;
            full_rejects++;
          end else begin
            members.insert(below, val);
            if (members.size() == capacity) times_filled++;
          end
        end
        CMD_DELETE: begin
          if (!present) begin
            r.st = ST_ABSENT;
            absent_deletes++;
          end else begin
            members.delete(below);
          end
        end
        CMD_GREATER: r.count = CNT_W'(above);
        CMD_LESS:    r.count = CNT_W'(below);
        default: ;
      endcase
      r.set_size = CNT_W'(members.size());
      awaited.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Checks one response transfer against the oldest prediction.
    function void check_response(logic [STAT_W-1:0] st, logic fnd, logic [CNT_W-1:0] cnt,
                                 logic [CNT_W-1:0] sz);
      response_t r;
      if (awaited.size() == 0) begin
        $display("%0t: response with nothing expected: status %0d found %0d count %0d size %0d",
                 $time, st, fnd, cnt, sz);
        errors++;
        return;
      end
      r = awaited.pop_front();
      checked++;
      compare_field("status", 32'(r.st), 32'(st));
      compare_field("found", 32'(r.found), 32'(fnd));
      compare_field("count", 32'(r.count), 32'(cnt));
      compare_field("set_size", 32'(r.set_size), 32'(sz));
    endfunction
  endclass

  // How the random part steers the set: fill it up to the limit, churn it at a
  // roughly steady size, or drain it back to empty.
  typedef enum {LOAD_FILL, LOAD_CHURN, LOAD_DRAIN} load_mode_e;

  logic              clk;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_ready;
  logic [CMD_W-1:0]  command;
  logic [VAL_W-1:0]  value;
  logic              rsp_valid;
  logic              rsp_ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  set_size;

  set_scoreboard sb;
  int            burst_left;
  int            drains;

  sorted_set_table #(.DEPTH(TABLE_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .found     (found),
    .count     (count),
    .set_size  (set_size)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every response transfer is checked at the rising edge where it happens.
  // rsp_ready only moves on falling edges, so it is stable here.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      sb.check_response(status, found, count, set_size);
  end

  // The response side runs its own stall pattern, independent of the sender.
  // It switches between stretches of constant readiness, coin-flip readiness
  // and long stalls, so back-pressure holds the sequencer's finish state for varying stretches.
  initial begin
    int mode;
    int stretch;
    rsp_ready = 1'b0;
    forever begin
      mode    = $urandom_range(2, 0);
      stretch = $urandom_range(200, 10);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0:       rsp_ready <= 1'b1;
          1:       rsp_ready <= 1'($urandom_range(1, 0));
          default: rsp_ready <= ($urandom_range(7, 0) == 0);
        endcase
      end
    end
  end

  // Drops valid and lets a gap of the given length go by. The payload is
  // scrambled while valid is low, since the block must ignore it then.
  task automatic pause_sender(input int cycles);
    @(negedge clk);
    cmd_valid <= 1'b0;
    command   <= CMD_W'($urandom);
    value     <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // Presents one command and holds it until the transfer happens. The sender
  // works in bursts: inside a burst valid stays high from one command to the
  // next, and each burst ends with a random gap.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int val);
    @(negedge clk);
    cmd_valid <= 1'b1;
    command   <= cmd;
    value     <= val;
    do @(posedge clk); while (!cmd_ready);
    sb.note_command(cmd, val);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause_sender($urandom_range(12, 1));
      // Now and then a long burst, so that stretches without sender gaps occur.
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
  endtask

  // Holds the sender off until every predicted response has been seen.
  task automatic drain_results();
    pause_sender(0);
    while (sb.pending() != 0) @(posedge clk);
    drains++;
  endtask

  // Value choice. With a hit bias, most values are current members or their
  // neighbors, which exercises duplicates, deletes that succeed and counts at
  // exact boundaries. Otherwise values come from a narrow window (to collide
  // later), the extremes of the range, or the whole 32-bit space.
  function automatic int pick_value(bit hit_bias);
    int roll;
    int pick;
    roll = $urandom_range(99, 0);
    if (sb.size() > 0 && roll < (hit_bias ? 70 : 10)) begin
      pick = sb.members[$urandom_range(sb.size() - 1, 0)];
      case ($urandom_range(5, 0))
        0:       return pick + 1;
        1:       return pick - 1;
        default: return pick;
      endcase
    end
    roll = $urandom_range(99, 0);
    if (roll < 45)
      return int'($urandom_range(64, 0)) - 32;
    if (roll < 60) begin
      case ($urandom_range(3, 0))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return 0;
        default: return -1;
      endcase
    end
    return int'($urandom);
  endfunction

  // Command mix for each load mode: mostly inserts while filling, mostly
  // deletes while draining, an even spread while churning. Spare codes show up
  // in every mode.
  function automatic logic [CMD_W-1:0] pick_command(load_mode_e mode);
    int roll;
    int ins_share;
    int del_share;
    roll = $urandom_range(99, 0);
    case (mode)
      LOAD_FILL:  begin ins_share = 65; del_share = 10; end
      LOAD_DRAIN: begin ins_share = 10; del_share = 65; end
      default:    begin ins_share = 25; del_share = 25; end
    endcase
    if (roll < ins_share) return CMD_INSERT;
    roll -= ins_share;
    if (roll < del_share) return CMD_DELETE;
    roll -= del_share;
    if (roll < 4) return CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    case (roll % 3)
      0:       return CMD_MEMBER;
      1:       return CMD_GREATER;
      default: return CMD_LESS;
    endcase
  endfunction

  initial begin
    load_mode_e       mode;
    logic [CMD_W-1:0] cmd;
    int               full_dwell;
    int               churn_left;
    int               spare;

    sb         = new(TABLE_DEPTH);
    burst_left = 0;
    drains     = 0;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    command    = CMD_MEMBER;
    value      = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Queries on the empty set come first, then the extremes of
    // the value range go in, a duplicate is rejected, counts are taken at both
    // ends and on a member (which neither count includes), the spare codes are
    // tried on a member and a non-member, and a delete repeats to hit absence.
    send_cmd(CMD_GREATER, 0);
    send_cmd(CMD_LESS, 0);
    send_cmd(CMD_MEMBER, VAL_MIN);
    send_cmd(CMD_DELETE, 5);
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_INSERT, VAL_MIN);
    send_cmd(CMD_INSERT, 0);
    send_cmd(CMD_INSERT, -1);
    send_cmd(CMD_INSERT, 1);
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_MEMBER, VAL_MIN);
    send_cmd(CMD_GREATER, VAL_MIN);
    send_cmd(CMD_LESS, VAL_MAX);
    send_cmd(CMD_GREATER, VAL_MAX);
    send_cmd(CMD_LESS, VAL_MIN);
    send_cmd(CMD_GREATER, -1);
    send_cmd(CMD_LESS, 32'sh5555_5555);
    for (spare = CMD_SPARE_FIRST; spare <= CMD_SPARE_LAST; spare++)
      send_cmd(CMD_W'(spare), (spare == CMD_SPARE_LAST) ? 32'shaaaa_aaaa : 0);
    send_cmd(CMD_DELETE, VAL_MIN);
    send_cmd(CMD_DELETE, VAL_MIN);
    send_cmd(CMD_DELETE, VAL_MAX);
    send_cmd(CMD_MEMBER, VAL_MAX);

    // The sender waits here for the directed responses before going random.
    drain_results();

    // Random part. The load mode cycles fill -> churn -> drain -> fill, so the
    // set reaches the full limit and empty several times. After filling, the
    // fill mode lingers a few commands to collect full and duplicate rejects.
    mode       = LOAD_FILL;
    full_dwell = $urandom_range(10, 3);
    churn_left = 0;
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      case (mode)
        LOAD_FILL: begin
          if (sb.size() == TABLE_DEPTH) begin
            if (full_dwell == 0) begin
              mode       = LOAD_CHURN;
              churn_left = $urandom_range(80, 30);
            end else begin
              full_dwell--;
            end
          end
        end
        LOAD_CHURN: begin
          if (churn_left == 0) mode = LOAD_DRAIN;
          else churn_left--;
        end
        default: begin
          if (sb.size() == 0) begin
            mode       = LOAD_FILL;
            full_dwell = $urandom_range(10, 3);
          end
        end
      endcase

      cmd = pick_command(mode);
      if (cmd == CMD_INSERT)
        send_cmd(cmd, pick_value((mode == LOAD_FILL && sb.size() == TABLE_DEPTH) ?
                                 1'($urandom_range(1, 0)) : 1'b0));
      else
        send_cmd(cmd, pick_value(1'b1));

      if ($urandom_range(59, 0) == 0)
        drain_results();
    end

    // Wait out the last responses, then give the block time to show any
    // response that it should not produce.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d commands (insert %0d, delete %0d, member %0d, greater %0d, less %0d)",
             RANDOM_COMMANDS + 24, sb.cmd_seen[CMD_INSERT], sb.cmd_seen[CMD_DELETE],
             sb.cmd_seen[CMD_MEMBER], sb.cmd_seen[CMD_GREATER], sb.cmd_seen[CMD_LESS]);
    $display("  %0d responses checked, store filled %0d times, %0d waits for an empty queue,",
             sb.checked, sb.times_filled, drains);
    $display("  %0d full / %0d duplicate / %0d absent rejects",
             sb.full_rejects, sb.dup_rejects, sb.absent_deletes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_sorted_set_table passed");
    end else begin
      $display("tb_sorted_set_table failed");
    end
    $finish;
  end

  // Watchdog. A correct run needs a few milliseconds of simulated time even
  // with every insert and delete at its slowest; this allows several times that.
  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d responses outstanding", $time, sb.pending());
    $display("tb_sorted_set_table failed");
    $finish;
  end

endmodule
